// ===== hdl/source_text_tokenizer_assert.svh =====
// Assertion macros for the tokenizer.
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define STT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tokenizer check failed");
`define STT_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("tokenizer check failed");
`else
`define STT_ASSERT(name, prop)
`define STT_ASSERT_ALWAYS(name, prop)
`endif
`endif

// ===== hdl/stt_pkg.sv =====
// Tokenizer package: token kinds, scanner modes, queue entry type, character helpers.
`timescale 1ns / 1ps
package stt_pkg;

  localparam int LEN_W = 6;

  localparam logic [5:0] K_EOF    = 6'd0;
  localparam logic [5:0] K_UNDEF  = 6'd1;
  localparam logic [5:0] K_IDENT  = 6'd2;
  localparam logic [5:0] K_INT    = 6'd3;
  localparam logic [5:0] K_FLOAT  = 6'd4;
  localparam logic [5:0] K_LIT    = 6'd5;
  localparam logic [5:0] K_DIV    = 6'd30;
  localparam logic [5:0] K_ASSIGN = 6'd32;
  localparam logic [5:0] K_GE     = 6'd33;
  localparam logic [5:0] K_GT     = 6'd34;
  localparam logic [5:0] K_LE     = 6'd35;
  localparam logic [5:0] K_NE     = 6'd36;
  localparam logic [5:0] K_LT     = 6'd37;

  localparam int NUM_KW = 15;
  localparam logic [47:0] KW_TXT [NUM_KW] = '{
    48'("class"), 48'("int"), 48'("string"), 48'("float"), 48'("if"),
    48'("else"), 48'("do"), 48'("while"), 48'("repeat"), 48'("until"),
    48'("read"), 48'("write"), 48'("not"), 48'("or"), 48'("and")};
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd5, 3'd3, 3'd6, 3'd5, 3'd2, 3'd4, 3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd5,
    3'd3, 3'd2, 3'd3};
  localparam logic [5:0] KW_KIND [NUM_KW] = '{
    6'd6, 6'd7, 6'd8, 6'd4, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15,
    6'd16, 6'd17, 6'd18, 6'd19};

  typedef enum logic [9:0] {
    M_IDLE  = 10'b00_0000_0001,
    M_OP    = 10'b00_0000_0010,
    M_LCOM  = 10'b00_0000_0100,
    M_BLOCK = 10'b00_0000_1000,
    M_BSTAR = 10'b00_0001_0000,
    M_IDENT = 10'b00_0010_0000,
    M_ZERO  = 10'b00_0100_0000,
    M_NUM   = 10'b00_1000_0000,
    M_FRAC  = 10'b01_0000_0000,
    M_STR   = 10'b10_0000_0000
  } mode_e;

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_FETCH = 3'b010,
    B_OUT   = 3'b100
  } back_e;

  // One queued token: either inline text (operators, eof) or a buffer bank.
  typedef struct packed {
    logic [5:0]       kind;
    logic [LEN_W-1:0] len;
    logic             trunc;
    logic             bank;
    logic             inl;
    logic [7:0]       c0;
    logic [7:0]       c1;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      8'h7b:   k = 6'd20;
      8'h7d:   k = 6'd21;
      8'h2c:   k = 6'd22;
      8'h3b:   k = 6'd23;
      8'h28:   k = 6'd24;
      8'h29:   k = 6'd25;
      8'h2d:   k = 6'd26;
      8'h3d:   k = 6'd27;
      8'h2b:   k = 6'd28;
      8'h2a:   k = 6'd29;
      8'h25:   k = 6'd31;
      default: k = K_UNDEF;
    endcase
    return k;
  endfunction

  // Kind of a held operator character when nothing joins it.
  function automatic logic [5:0] held_alone_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      8'h2f:   k = K_DIV;
      8'h3e:   k = K_GT;
      8'h3c:   k = K_LT;
      default: k = K_UNDEF;
    endcase
    return k;
  endfunction

  // Character i of keyword k; strings sit right-aligned, first char highest.
  function automatic logic [7:0] kw_char(input int k, input logic [2:0] i);
    int sh;
    sh = 8 * (int'(KW_LEN[k]) - 1 - int'(i));
    if (sh < 0) sh = 0;
    return KW_TXT[k][sh +: 8];
  endfunction

endpackage

// ===== hdl/stt_if.sv =====
// Request channel interfaces: source bytes in, lexeme characters out.
`timescale 1ns / 1ps
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       at_end;
  modport source (output valid, ch, at_end, input ready);
  modport sink (input valid, ch, at_end, output ready);
endinterface

interface stt_out_if #(parameter int LINE_BITS = 16);
  logic                 valid;
  logic                 ready;
  logic [7:0]           lexeme_char;
  logic                 char_valid;
  logic                 token_end;
  logic [5:0]           token_kind;
  logic [LINE_BITS-1:0] line_number;
  logic                 truncated;
  modport source (output valid, lexeme_char, char_valid, token_end, token_kind,
                  line_number, truncated, input ready);
  modport sink (input valid, lexeme_char, char_valid, token_end, token_kind,
                line_number, truncated, output ready);
endinterface

// ===== hdl/source_text_tokenizer.sv =====
// Top level of the streaming source text tokenizer.
//
//  channel | dir | handshake     | payload
//  in_i    | in  | valid / ready | ch[7:0], at_end
//  out_o   | out | valid / ready | lexeme_char, char_valid, token_end, token_kind,
//          |     |               | line_number, truncated
//
// Scanner: one byte request per cycle while the token queue has room and its lexeme
// bank is free; a byte that closes one token and yields another parks the second in a
// holding register and blocks input until it is queued. Mid-lexeme it waits for the
// other bank. Emitter: a buffered character is read from its bank, then requested;
// operator, end and empty tokens need no read, and each token is first pulled from queue.
// Reset: scanner idle, line count one, queue empty; buffers need no clearing.
`timescale 1ns / 1ps
`include "source_text_tokenizer_assert.svh"
module source_text_tokenizer import stt_pkg::*; #(
  parameter int MAX_LEXEME = 32,
  parameter int LINE_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stt_in_if.sink    in_i,
  stt_out_if.source out_o
);
  // buffer address covers both banks
  localparam int AW = $clog2(2 * MAX_LEXEME);
  localparam int QW = $bits(cmd_t) + LINE_BITS;

  logic                 q_push, q_full, q_pop, q_valid;
  cmd_t                 push_cmd, q_cmd;
  logic [LINE_BITS-1:0] push_line, q_line;
  logic [QW-1:0]        q_data;
  release_t             rel;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [7:0]           wdata;

  stt_front #(.MAX_LEXEME(MAX_LEXEME), .LINE_BITS(LINE_BITS), .AW(AW)) u_front (
    .clk_i, .rst_ni, .in_i,
    .push_o(q_push), .push_cmd_o(push_cmd), .push_line_o(push_line),
    .full_i(q_full), .rel_i(rel),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata)
  );

  // token queue decouples scanning from character playout
  stt_fifo #(.WIDTH(QW)) u_queue (
    .clk_i, .rst_ni,
    .push_i(q_push), .push_data_i({push_line, push_cmd}), .full_o(q_full),
    .pop_i(q_pop), .valid_o(q_valid), .data_o(q_data)
  );

  assign q_cmd  = q_data[$bits(cmd_t)-1:0];
  assign q_line = q_data[QW-1:$bits(cmd_t)];

  stt_back #(.MAX_LEXEME(MAX_LEXEME), .LINE_BITS(LINE_BITS), .AW(AW)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_cmd_i(q_cmd), .q_line_i(q_line), .pop_o(q_pop),
    .rel_o(rel), .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .out_o
  );

  // an empty lexeme is always a single, closing request
  `STT_ASSERT(a_empty_closes, out_o.valid && !out_o.char_valid |-> out_o.token_end)
  // the end token never carries a character
  `STT_ASSERT(a_eof_empty, out_o.valid && out_o.token_kind == K_EOF |-> !out_o.char_valid)
  // the scanner never pushes into a full queue
  `STT_ASSERT(a_no_overflow, q_push |-> !q_full)
  // emitter takes a token only when the queue holds one
  `STT_ASSERT_ALWAYS(a_pop_valid, q_pop |-> q_valid)
endmodule

// ===== hdl/stt_fifo.sv =====
// Four-entry token queue between scanner and emitter.
`timescale 1ns / 1ps
module stt_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  logic [WIDTH-1:0] mem_q [4];
  logic [1:0] wr_q, wr_d, rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 3'd4);
  assign valid_o = (cnt_q != 3'd0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 2'd1 : wr_q;
    rd_d  = pop_i ? rd_q + 2'd1 : rd_q;
    cnt_d = cnt_q + {2'b00, push_i} - {2'b00, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end
endmodule

// ===== hdl/stt_front.sv =====
// Scanner: classifies bytes, builds lexemes into two buffer banks, queues tokens.
`timescale 1ns / 1ps
module stt_front import stt_pkg::*; #(
  parameter int MAX_LEXEME = 32,
  parameter int LINE_BITS  = 16,
  parameter int AW         = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  stt_in_if.sink               in_i,
  output logic                 push_o,
  output cmd_t                 push_cmd_o,
  output logic [LINE_BITS-1:0] push_line_o,
  input  logic                 full_i,
  input  release_t             rel_i,
  output logic                 we_o,
  output logic [AW-1:0]        waddr_o,
  output logic [7:0]           wdata_o
);
  localparam logic [LEN_W-1:0] MAXL = LEN_W'(MAX_LEXEME);
  localparam logic [LINE_BITS-1:0] LINE_TOP = '1;

  mode_e                mode_q, mode_d;
  logic [7:0]           held_q, held_d;
  logic                 frac_q, frac_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic [LINE_BITS-1:0] line_q, line_d, start_q, start_d;
  logic                 wb_q, wb_d;
  logic [NUM_KW-1:0]    kw_q, kw_d;
  logic [1:0]           busy_q, busy_d;
  logic                 sec_v_q;
  cmd_t                 sec_q;
  logic [LINE_BITS-1:0] sec_line_q;

  logic                 accept, bank_mode, redo, app;
  logic [7:0]           c;
  logic [1:0]           n;
  cmd_t                 cmd [2];
  logic [LINE_BITS-1:0] cl [2];

  assign c = in_i.ch;
  assign bank_mode = (mode_q == M_IDENT) || (mode_q == M_ZERO) || (mode_q == M_NUM) ||
                     (mode_q == M_FRAC) || (mode_q == M_STR);
  assign in_i.ready = !sec_v_q && !full_i && !busy_q[wb_q] &&
                      !(bank_mode && busy_q[~wb_q]);
  assign accept = in_i.valid && in_i.ready;

  function automatic logic [5:0] ident_kind(input logic [LEN_W-1:0] len,
                                            input logic [NUM_KW-1:0] kw);
    logic [5:0] k;
    k = K_IDENT;
    if (len <= MAXL) begin
      for (int i = 0; i < NUM_KW; i++) begin
        if (kw[i] && (len == LEN_W'(KW_LEN[i]))) k = KW_KIND[i];
      end
    end
    return k;
  endfunction

  always_comb begin
    mode_d  = mode_q;
    held_d  = held_q;
    frac_d  = frac_q;
    len_d   = len_q;
    line_d  = line_q;
    start_d = start_q;
    wb_d    = wb_q;
    kw_d    = kw_q;
    busy_d  = busy_q;
    redo    = 1'b0;
    app     = 1'b0;
    n       = 2'd0;
    cmd[0]  = '0;
    cmd[1]  = '0;
    cl[0]   = start_q;
    cl[1]   = start_q;
    we_o    = 1'b0;
    waddr_o = '0;
    wdata_o = c;

    if (rel_i.valid) busy_d[rel_i.bank] = 1'b0;

    if (accept) begin
      if (in_i.at_end) begin
        // flush a pending operator, word or number, then the end token; an open string is dropped
        case (mode_q)
          M_OP: begin
            cmd[0] = '{kind: held_alone_kind(held_q), len: LEN_W'(1), trunc: 1'b0,
                       bank: 1'b0, inl: 1'b1, c0: held_q, c1: 8'h00};
            n = 2'd1;
          end
          M_IDENT, M_ZERO, M_NUM, M_FRAC: begin
            cmd[0].kind  = (mode_q == M_IDENT) ? ident_kind(len_q, kw_q) :
                           ((mode_q == M_FRAC) && frac_q) ? K_FLOAT : K_INT;
            cmd[0].len   = (len_q > MAXL) ? MAXL : len_q;
            cmd[0].trunc = (len_q > MAXL);
            cmd[0].bank  = wb_q;
            busy_d[wb_q] = 1'b1;
            wb_d = ~wb_q;
            n = 2'd1;
          end
          default: ;
        endcase
        cmd[n[0]] = '{kind: K_EOF, len: '0, trunc: 1'b0, bank: 1'b0, inl: 1'b1,
                      c0: 8'h00, c1: 8'h00};
        cl[n[0]]  = line_q;
        start_d   = line_q;
        n = n + 2'd1;
        mode_d = M_IDLE;
        held_d = '0;
        frac_d = 1'b0;
        len_d  = '0;
      end else begin
        case (mode_q)
          M_OP: begin
            held_d = '0;
            mode_d = M_IDLE;
            if (held_q == 8'h2f && c == 8'h2f) begin
              mode_d = M_LCOM;
              len_d = '0;
            end else if (held_q == 8'h2f && c == 8'h2a) begin
              mode_d = M_BLOCK;
              len_d = '0;
            end else if (c == 8'h3d &&
                         (held_q == 8'h3a || held_q == 8'h3e || held_q == 8'h3c)) begin
              cmd[0] = '{kind: (held_q == 8'h3a) ? K_ASSIGN :
                               (held_q == 8'h3e) ? K_GE : K_LE,
                         len: LEN_W'(2), trunc: 1'b0, bank: 1'b0, inl: 1'b1,
                         c0: held_q, c1: c};
              n = 2'd1;
            end else if (c == 8'h3e && held_q == 8'h3c) begin
              cmd[0] = '{kind: K_NE, len: LEN_W'(2), trunc: 1'b0, bank: 1'b0,
                         inl: 1'b1, c0: held_q, c1: c};
              n = 2'd1;
            end else begin
              cmd[0] = '{kind: held_alone_kind(held_q), len: LEN_W'(1), trunc: 1'b0,
                         bank: 1'b0, inl: 1'b1, c0: held_q, c1: 8'h00};
              n = 2'd1;
              redo = 1'b1;
            end
          end
          M_LCOM: redo = (c == 8'h0a);
          M_BLOCK: if (c == 8'h2a) mode_d = M_BSTAR;
          M_BSTAR: begin
            if (c == 8'h2f) mode_d = M_IDLE;
            else if (c != 8'h2a) mode_d = M_BLOCK;
          end
          M_IDENT, M_ZERO, M_NUM, M_FRAC: begin
            if ((mode_q == M_IDENT && (is_alpha(c) || is_digit(c))) ||
                (mode_q == M_NUM && is_digit(c))) begin
              app = 1'b1;
            end else if ((mode_q == M_ZERO || mode_q == M_NUM) && c == 8'h2e) begin
              app = 1'b1;
              frac_d = 1'b0;
              mode_d = M_FRAC;
            end else if (mode_q == M_FRAC && is_digit(c)) begin
              app = 1'b1;
              frac_d = 1'b1;
            end else begin
              cmd[0].kind  = (mode_q == M_IDENT) ? ident_kind(len_q, kw_q) :
                             ((mode_q == M_FRAC) && frac_q) ? K_FLOAT : K_INT;
              cmd[0].len   = (len_q > MAXL) ? MAXL : len_q;
              cmd[0].trunc = (len_q > MAXL);
              cmd[0].bank  = wb_q;
              busy_d[wb_q] = 1'b1;
              wb_d   = ~wb_q;
              len_d  = '0;
              frac_d = 1'b0;
              n = 2'd1;
              redo = 1'b1;
            end
          end
          M_STR: begin
            if (c == 8'h22) begin
              cmd[0].kind  = K_LIT;
              cmd[0].len   = (len_q > MAXL) ? MAXL : len_q;
              cmd[0].trunc = (len_q > MAXL);
              cmd[0].bank  = wb_q;
              busy_d[wb_q] = 1'b1;
              wb_d   = ~wb_q;
              len_d  = '0;
              mode_d = M_IDLE;
              n = 2'd1;
            end else begin
              app = 1'b1;
            end
          end
          default: redo = 1'b1;
        endcase

        // byte handled afresh between tokens
        if (redo) begin
          mode_d = M_IDLE;
          if (is_space(c)) begin
            if (c == 8'h0a && line_q != LINE_TOP) line_d = line_q + 1'b1;
          end else begin
            start_d = line_q;
            len_d   = '0;
            kw_d    = '1;
            if (c == 8'h2f || c == 8'h3a || c == 8'h3c || c == 8'h3e) begin
              held_d = c;
              mode_d = M_OP;
            end else if (is_alpha(c)) begin
              app = 1'b1;
              mode_d = M_IDENT;
            end else if (c == 8'h30) begin
              app = 1'b1;
              mode_d = M_ZERO;
            end else if (is_digit(c)) begin
              app = 1'b1;
              mode_d = M_NUM;
            end else if (c == 8'h22) begin
              mode_d = M_STR;
            end else begin
              cmd[n[0]] = '{kind: single_kind(c), len: LEN_W'(1), trunc: 1'b0,
                            bank: 1'b0, inl: 1'b1, c0: c, c1: 8'h00};
              cl[n[0]] = line_q;
              n = n + 2'd1;
            end
          end
        end

        if (app) begin
          if (len_d < MAXL) begin
            we_o    = 1'b1;
            waddr_o = wb_d ? AW'(MAX_LEXEME) + AW'(len_d) : AW'(len_d);
            for (int i = 0; i < NUM_KW; i++) begin
              kw_d[i] = kw_d[i] && (len_d < LEN_W'(KW_LEN[i])) &&
                        (c == kw_char(i, len_d[2:0]));
            end
            len_d = len_d + 1'b1;
          end else begin
            len_d = MAXL + 1'b1;
            kw_d  = '0;
          end
        end
      end
    end
  end

  always_comb begin
    push_o      = 1'b0;
    push_cmd_o  = cmd[0];
    push_line_o = cl[0];
    if (sec_v_q) begin
      push_o      = !full_i;
      push_cmd_o  = sec_q;
      push_line_o = sec_line_q;
    end else if (accept && n != 2'd0) begin
      push_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      held_q  <= '0;
      frac_q  <= 1'b0;
      len_q   <= '0;
      line_q  <= LINE_BITS'(1);
      start_q <= LINE_BITS'(1);
      wb_q    <= 1'b0;
      kw_q    <= '0;
      busy_q  <= '0;
      sec_v_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      held_q  <= held_d;
      frac_q  <= frac_d;
      len_q   <= len_d;
      line_q  <= line_d;
      start_q <= start_d;
      wb_q    <= wb_d;
      kw_q    <= kw_d;
      busy_q  <= busy_d;
      if (sec_v_q && !full_i) sec_v_q <= 1'b0;
      else if (accept && n == 2'd2) sec_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && n == 2'd2) begin
      sec_q      <= cmd[1];
      sec_line_q <= cl[1];
    end
  end
endmodule

// ===== hdl/stt_back.sv =====
// Emitter: holds the lexeme buffer banks and plays tokens out one character per request.
`timescale 1ns / 1ps
module stt_back import stt_pkg::*; #(
  parameter int MAX_LEXEME = 32,
  parameter int LINE_BITS  = 16,
  parameter int AW         = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  cmd_t                 q_cmd_i,
  input  logic [LINE_BITS-1:0] q_line_i,
  output logic                 pop_o,
  output release_t             rel_o,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [7:0]           wdata_i,
  stt_out_if.source            out_o
);
  logic [7:0] mem [2*MAX_LEXEME];
  logic [7:0] rd_q;
  logic [AW-1:0] raddr;

  back_e                state_q, state_d;
  cmd_t                 cur_q;
  logic [LINE_BITS-1:0] cur_line_q;
  logic [LEN_W-1:0]     idx_q, idx_d;
  logic                 last;

  assign raddr = cur_q.bank ? AW'(MAX_LEXEME) + AW'(idx_q) : AW'(idx_q);

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rd_q <= mem[raddr];
  end

  assign last  = (cur_q.len == '0) || (idx_q + 1'b1 == cur_q.len);
  assign pop_o = (state_q == B_IDLE) && q_valid_i;

  assign out_o.valid       = (state_q == B_OUT);
  assign out_o.char_valid  = (cur_q.len != '0);
  assign out_o.token_end   = last;
  assign out_o.token_kind  = cur_q.kind;
  assign out_o.line_number = cur_line_q;
  assign out_o.truncated   = cur_q.trunc;
  assign out_o.lexeme_char = (cur_q.len == '0) ? 8'h00 :
                             cur_q.inl ? (idx_q[0] ? cur_q.c1 : cur_q.c0) : rd_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    rel_o   = '{valid: 1'b0, bank: cur_q.bank};
    case (state_q)
      B_IDLE: begin
        idx_d = '0;
        if (q_valid_i) begin
          state_d = (q_cmd_i.inl || q_cmd_i.len == '0) ? B_OUT : B_FETCH;
        end
      end
      B_FETCH: state_d = B_OUT;
      B_OUT: begin
        if (out_o.ready) begin
          if (last) begin
            rel_o.valid = !cur_q.inl;
            state_d = B_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
            state_d = cur_q.inl ? B_OUT : B_FETCH;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q      <= q_cmd_i;
      cur_line_q <= q_line_i;
    end
  end
endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the source text tokenizer: stream predictor and result scoreboard.
`timescale 1ns / 1ps
module tb;
  import stt_pkg::*;

  // Kinds not named by the package
  localparam logic [5:0] K_CLASS  = 6'd6;
  localparam logic [5:0] K_INTKW  = 6'd7;
  localparam logic [5:0] K_STRING = 6'd8;
  localparam logic [5:0] K_IF     = 6'd9;
  localparam logic [5:0] K_ELSE   = 6'd10;
  localparam logic [5:0] K_DO     = 6'd11;
  localparam logic [5:0] K_WHILE  = 6'd12;
  localparam logic [5:0] K_REPEAT = 6'd13;
  localparam logic [5:0] K_UNTIL  = 6'd14;
  localparam logic [5:0] K_READ   = 6'd15;
  localparam logic [5:0] K_WRITE  = 6'd16;
  localparam logic [5:0] K_NOT    = 6'd17;
  localparam logic [5:0] K_OR     = 6'd18;
  localparam logic [5:0] K_AND    = 6'd19;
  localparam logic [5:0] K_LBRACE = 6'd20;
  localparam logic [5:0] K_RBRACE = 6'd21;
  localparam logic [5:0] K_COMMA  = 6'd22;
  localparam logic [5:0] K_SEMI   = 6'd23;
  localparam logic [5:0] K_LPAREN = 6'd24;
  localparam logic [5:0] K_RPAREN = 6'd25;
  localparam logic [5:0] K_MINUS  = 6'd26;
  localparam logic [5:0] K_EQ     = 6'd27;
  localparam logic [5:0] K_PLUS   = 6'd28;
  localparam logic [5:0] K_STAR   = 6'd29;
  localparam logic [5:0] K_MOD    = 6'd31;

  localparam int MAXLEX    = 32;
  localparam logic [15:0] LINE_MAX = 16'hFFFF;
  localparam int WATCHDOG  = 20000;
  localparam int END_WAIT  = 100;

  typedef struct packed {
    logic [7:0]  lchar;
    logic        cvalid;
    logic        tend;
    logic [5:0]  kind;
    logic [15:0] line;
    logic        trunc;
  } lex_item_t;

  logic clk_i;
  logic rst_ni;

  stt_in_if             src ();
  stt_out_if #(.LINE_BITS(16)) snk ();

  source_text_tokenizer #(.MAX_LEXEME(MAXLEX), .LINE_BITS(16)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (src.sink),
    .out_o  (snk.source)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Predictor state
  mode_e       sc_mode;
  logic [7:0]  sc_buf [MAXLEX];
  int          sc_len;
  logic [7:0]  sc_held;
  logic        sc_frac;
  logic [15:0] sc_line;
  logic [15:0] sc_start;

  lex_item_t expected_chars [$];
  int        errors;
  int        idle_pct;
  int        stall_pct;
  int        hold_cycles;
  int        quiet_cycles;

  function automatic logic dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic logic blank(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [5:0] op_kind(logic [7:0] c);
    case (c)
      "{": return K_LBRACE;
      "}": return K_RBRACE;
      ",": return K_COMMA;
      ";": return K_SEMI;
      "(": return K_LPAREN;
      ")": return K_RPAREN;
      "-": return K_MINUS;
      "=": return K_EQ;
      "+": return K_PLUS;
      "*": return K_STAR;
      "%": return K_MOD;
      default: return K_UNDEF;
    endcase
  endfunction

  function automatic logic [5:0] lone_kind(logic [7:0] c);
    if (c == "/") return K_DIV;
    if (c == ">") return K_GT;
    if (c == "<") return K_LT;
    return K_UNDEF;
  endfunction

  function automatic logic [5:0] word_kind();
    string s;
    s = "";
    if (sc_len > MAXLEX) return K_IDENT;
    for (int i = 0; i < sc_len; i++) s = {s, string'(sc_buf[i])};
    case (s)
      "class":  return K_CLASS;
      "int":    return K_INTKW;
      "string": return K_STRING;
      "float":  return K_FLOAT;
      "if":     return K_IF;
      "else":   return K_ELSE;
      "do":     return K_DO;
      "while":  return K_WHILE;
      "repeat": return K_REPEAT;
      "until":  return K_UNTIL;
      "read":   return K_READ;
      "write":  return K_WRITE;
      "not":    return K_NOT;
      "or":     return K_OR;
      "and":    return K_AND;
      default:  return K_IDENT;
    endcase
  endfunction

  function automatic void add_char(logic [7:0] c);
    if (sc_len < MAXLEX) begin
      sc_buf[sc_len] = c;
      sc_len++;
    end else begin
      sc_len = MAXLEX + 1;
    end
  endfunction

  // Queue the lexeme as one request per character, or one closing request if it is empty
  function automatic void queue_token(logic [5:0] k);
    int n;
    logic t;
    lex_item_t it;
    n = (sc_len > MAXLEX) ? MAXLEX : sc_len;
    t = sc_len > MAXLEX;
    it.kind = k;
    it.line = sc_start;
    it.trunc = t;
    if (n == 0) begin
      it.lchar = 8'd0; it.cvalid = 1'b0; it.tend = 1'b1;
      expected_chars = {expected_chars, it};
    end else begin
      for (int i = 0; i < n; i++) begin
        it.lchar = sc_buf[i]; it.cvalid = 1'b1; it.tend = (i == n - 1);
        expected_chars = {expected_chars, it};
      end
    end
    sc_len = 0;
  endfunction

  function automatic void from_idle(logic [7:0] c);
    sc_mode = M_IDLE;
    if (blank(c)) begin
      if (c == 8'h0a && sc_line != LINE_MAX) sc_line++;
      return;
    end
    sc_start = sc_line;
    sc_len = 0;
    if (c == "/" || c == ":" || c == "<" || c == ">") begin
      sc_held = c;
      sc_mode = M_OP;
    end else if (alpha(c)) begin
      add_char(c); sc_mode = M_IDENT;
    end else if (c == "0") begin
      add_char(c); sc_mode = M_ZERO;
    end else if (dig(c)) begin
      add_char(c); sc_mode = M_NUM;
    end else if (c == 8'h22) begin
      sc_mode = M_STR;
    end else begin
      add_char(c);
      queue_token(op_kind(c));
    end
  endfunction

  function automatic void predict_tokens(logic [7:0] c, logic eof);
    logic [7:0] h;
    if (eof) begin
      case (sc_mode)
        M_OP: begin
          add_char(sc_held);
          queue_token(lone_kind(sc_held));
        end
        M_IDENT: queue_token(word_kind());
        M_ZERO, M_NUM: queue_token(K_INT);
        M_FRAC: queue_token(sc_frac ? K_FLOAT : K_INT);
        default: ;
      endcase
      sc_held = 8'd0; sc_frac = 1'b0; sc_len = 0; sc_mode = M_IDLE;
      sc_start = sc_line;
      queue_token(K_EOF);
      return;
    end
    case (sc_mode)
      M_OP: begin
        h = sc_held;
        sc_held = 8'd0;
        if (h == "/" && c == "/") begin
          sc_mode = M_LCOM; sc_len = 0;
        end else if (h == "/" && c == "*") begin
          sc_mode = M_BLOCK; sc_len = 0;
        end else begin
          add_char(h);
          if (c == "=" && (h == ":" || h == ">" || h == "<")) begin
            add_char(c);
            queue_token(h == ":" ? K_ASSIGN : (h == ">" ? K_GE : K_LE));
            sc_mode = M_IDLE;
          end else if (c == ">" && h == "<") begin
            add_char(c);
            queue_token(K_NE);
            sc_mode = M_IDLE;
          end else begin
            queue_token(lone_kind(h));
            from_idle(c);
          end
        end
      end
      M_LCOM: if (c == 8'h0a) from_idle(c);
      M_BLOCK: if (c == "*") sc_mode = M_BSTAR;
      M_BSTAR: begin
        if (c == "/") sc_mode = M_IDLE;
        else if (c != "*") sc_mode = M_BLOCK;
      end
      M_IDENT: begin
        if (alpha(c) || dig(c)) add_char(c);
        else begin
          queue_token(word_kind());
          from_idle(c);
        end
      end
      M_ZERO, M_NUM: begin
        if (sc_mode == M_NUM && dig(c)) add_char(c);
        else if (c == ".") begin
          add_char(c); sc_frac = 1'b0; sc_mode = M_FRAC;
        end else begin
          queue_token(K_INT);
          from_idle(c);
        end
      end
      M_FRAC: begin
        if (dig(c)) begin
          add_char(c); sc_frac = 1'b1;
        end else begin
          queue_token(sc_frac ? K_FLOAT : K_INT);
          sc_frac = 1'b0;
          from_idle(c);
        end
      end
      M_STR: begin
        if (c == 8'h22) begin
          queue_token(K_LIT); sc_mode = M_IDLE;
        end else begin
          add_char(c);
        end
      end
      default: from_idle(c);
    endcase
  endfunction

  // One byte request; sender gaps are drawn before it goes out
  task automatic send_byte(logic [7:0] c, logic eof);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      src.valid = 1'b0;
      @(negedge clk_i);
    end
    src.valid  = 1'b1;
    src.ch     = c;
    src.at_end = eof;
    forever begin
      @(posedge clk_i);
      if (src.ready) break;
    end
    predict_tokens(c, eof);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic send_eof();
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic drain();
    @(negedge clk_i);
    src.valid = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls plus an optional long hold
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      snk.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      snk.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Scoreboard: each output request against the oldest expectation
  always @(posedge clk_i) begin
    lex_item_t got, want;
    if (rst_ni && snk.valid && snk.ready) begin
      got = '{snk.lexeme_char, snk.char_valid, snk.token_end, snk.token_kind,
              snk.line_number, snk.truncated};
      if (expected_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected output %p", $time, got);
      end else begin
        want = expected_chars.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
        end
      end
    end
  end

  // Watchdog on cycles with no request moving either way
  always @(posedge clk_i) begin
    if ((src.valid && src.ready) || (snk.valid && snk.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------- directed tests ----------------

  task automatic test_keywords_and_words();
    send_text("class repeat until x9Q ");
  endtask

  task automatic test_numbers();
    send_text("0123 12. 3.14 ");
  endtask

  task automatic test_operators();
    send_text("<=<><>=>:=:/{}\"ab\"");
  endtask

  task automatic test_comments_and_lines();
    send_text("//c\n/**x*/\n+");
  endtask

  task automatic test_odd_bytes();
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b0);
  endtask

  task automatic test_long_lexeme();
    for (int i = 0; i < 36; i++) send_byte(8'("a" + (i % 26)), 1'b0);
    send_text(" \"");
    for (int i = 0; i < 34; i++) send_byte(8'("A" + (i % 26)), 1'b0);
    send_text("\"");
  endtask

  task automatic test_end_marks();
    send_text("ab");
    send_eof();
    send_eof();
    send_text("\"cut");
    send_eof();
  endtask

  // ---------------- random stimulus ----------------

  task automatic send_random_token();
    int pick, n;
    string kw [15] = '{"class", "int", "string", "float", "if", "else", "do", "while",
                       "repeat", "until", "read", "write", "not", "or", "and"};
    string ops [16] = '{"{", "}", ",", ";", "(", ")", "-", "=", "+", "*", "%", "/",
                        ":=", ">=", "<=", "<>"};
    pick = $urandom_range(99);
    if (pick < 12) send_text(kw[$urandom_range(14)]);
    else if (pick < 27) begin
      n = ($urandom_range(15) == 0) ? $urandom_range(33, 38) : $urandom_range(1, 6);
      send_byte(alpha(8'(pick)) ? 8'(pick) : 8'("a" + $urandom_range(25)), 1'b0);
      for (int i = 1; i < n; i++) begin
        case ($urandom_range(2))
          0: send_byte(8'("a" + $urandom_range(25)), 1'b0);
          1: send_byte(8'("A" + $urandom_range(25)), 1'b0);
          default: send_byte(8'("0" + $urandom_range(9)), 1'b0);
        endcase
      end
    end else if (pick < 40) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) send_byte(8'("0" + $urandom_range(9)), 1'b0);
      if ($urandom_range(1)) begin
        send_byte(".", 1'b0);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) send_byte(8'("0" + $urandom_range(9)), 1'b0);
      end
    end else if (pick < 48) begin
      send_byte(8'h22, 1'b0);
      n = ($urandom_range(9) == 0) ? $urandom_range(32, 36) : $urandom_range(0, 5);
      for (int i = 0; i < n; i++) begin
        logic [7:0] c;
        c = 8'($urandom_range(255));
        if (c == 8'h22) c = "q";
        send_byte(c, 1'b0);
      end
      send_byte(8'h22, 1'b0);
    end else if (pick < 66) send_text(ops[$urandom_range(15)]);
    else if (pick < 72) send_text($urandom_range(1) ? "//r x\n" : "/* *q* */");
    else if (pick < 80) begin
      send_byte($urandom_range(1) ? 8'h0a : 8'(9 + $urandom_range(4)), 1'b0);
    end
    else if (pick < 95) send_byte(8'($urandom_range(255)), 1'b0);
    else if (pick < 97) send_text(pick[0] ? "<" : ">");
    else send_eof();
    // separator, sometimes absent so tokens abut
    if ($urandom_range(3) != 0) send_byte(" ", 1'b0);
  endtask

  task automatic test_random_phase(int n_items, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n_items; i++) send_random_token();
    send_eof();
    drain();
  endtask

  // Receiver held off while bytes keep coming so the block backs up
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) send_random_token();
    send_eof();
    drain();
  endtask

  initial begin
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    src.valid = 1'b0;
    src.ch = 8'd0;
    src.at_end = 1'b0;
    snk.ready = 1'b0;
    sc_mode = M_IDLE;
    sc_len = 0;
    sc_held = 8'd0;
    sc_frac = 1'b0;
    sc_line = 16'd1;
    sc_start = 16'd1;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_keywords_and_words();
    test_numbers();
    test_operators();
    test_comments_and_lines();
    test_odd_bytes();
    test_long_lexeme();
    test_end_marks();
    drain();

    test_random_phase(14, 0, 0);
    test_random_phase(14, 79, 0);
    test_random_phase(14, 0, 79);
    test_random_phase(14, 29, 29);
    test_backpressure();
    drain();

    repeat (END_WAIT) @(posedge clk_i);
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/stt_pkg.sv
hdl/stt_if.sv
hdl/stt_fifo.sv
hdl/stt_front.sv
hdl/stt_back.sv
hdl/source_text_tokenizer.sv
bench/tb.sv
